### sv/rpn_pkg.sv
package rpn_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int VAL_W    = 32;
    localparam int NUM_W    = 31;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMAIN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FEW      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Divider iteration count
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

endpackage

### sv/rpn_div.sv
// Signed truncating divider, one restoring step per cycle on magnitudes,
// sign applied in a final cycle. Quotient wraps (most negative / -1).
module rpn_div
    import rpn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] dividend,
    input  logic [VAL_W-1:0] divisor,
    output logic             done,
    output logic [VAL_W-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  dvd_reg;
    logic [VAL_W-1:0]  dvs_reg;
    logic [VAL_W-1:0]  quo_reg;

    logic [VAL_W:0]    trial;
    logic              q_bit;
    logic [VAL_W:0]    diff;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[VAL_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        q_bit = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_STEPS);
                rem_reg  <= '0;
                neg_reg  <= dividend[VAL_W-1] ^ divisor[VAL_W-1];
                dvd_reg  <= dividend[VAL_W-1] ? (VAL_W'(0) - dividend) : dividend;
                dvs_reg  <= divisor[VAL_W-1] ? (VAL_W'(0) - divisor) : divisor;
            end
            else if (busy_reg && step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
                rem_reg  <= q_bit ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
                dvd_reg  <= {dvd_reg[VAL_W-2:0], q_bit};
            end
            else if (busy_reg)
            begin
                // quotient bits now fill dvd_reg; apply sign
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                quo_reg  <= neg_reg ? (VAL_W'(0) - dvd_reg) : dvd_reg;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/rpn_stack_evaluator_core.sv
// Channel | Signals                          | Direction
// --------+----------------------------------+-------------------------------
// in      | in_valid, in_stall, op, number   | beat in, one token per beat
// out     | out_valid, out_stall, status,    | beat out, one result per token
//         | top_value, depth                 |
//
// Push, finish, unused codes, too few operands, stack full: accept, then done state
// loads the output reg. Add, subtract, multiply, divide by zero: stack memory read,
// execute, then done. Divide: memory read, the 32-step divider, then done. Input
// reopens the cycle after the output reg loads: one token in flight at a time.
// Reset clears the stack count; stack memory contents are not cleared.
// out_stall holds a finished result in the done state until the register frees.
module rpn_stack_evaluator_core
    import rpn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [NUM_W-1:0]    number,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VAL_W-1:0]    top_value,
    output logic [DEPTH_W-1:0]  depth
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_DONE} state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [VAL_W-1:0]    top_reg;
    logic [OP_W-1:0]     op_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [VAL_W-1:0]    res_value_reg;
    logic [CNT_W-1:0]    ncount_reg;
    logic                wr_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VAL_W-1:0]    top_value_reg;
    logic [DEPTH_W-1:0]  depth_reg;

    // Stack memory, one write and one registered read port
    logic [VAL_W-1:0]    stack_mem [STACK_DEPTH];
    logic [VAL_W-1:0]    rd_data_reg;

    logic                accept;
    logic                out_free;
    logic                is_arith;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic                div_start;
    logic                div_done;
    logic [VAL_W-1:0]    div_quot;

    // Handshake and memory control
    always_comb
    begin
        accept    = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
        is_arith  = op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        rd_en     = accept && is_arith && (count_reg >= CNT_W'(2));
        rd_addr   = ADDR_W'(count_reg - CNT_W'(2));
        mem_we    = (state_reg == S_DONE) && out_free && wr_reg;
        wr_addr   = ADDR_W'(ncount_reg - CNT_W'(1));
        div_start = (state_reg == S_CALC) && (op_reg == OP_DIV) && (top_reg != '0);
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= res_value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            top_reg        <= '0;
            op_reg         <= OP_PUSH;
            res_status_reg <= ST_OK;
            res_value_reg  <= '0;
            ncount_reg     <= '0;
            wr_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            top_value_reg  <= '0;
            depth_reg      <= '0;
        end
        else
        begin
            // in the done state the output beat is reloaded instead
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= op;
                        res_status_reg <= ST_OK;
                        res_value_reg  <= '0;
                        ncount_reg     <= '0;
                        wr_reg         <= 1'b0;
                        state_reg      <= S_DONE;
                        case (op)
                            OP_PUSH:
                            begin
                                if (count_reg == CNT_W'(STACK_DEPTH))
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    res_value_reg <= {1'b0, number};
                                    ncount_reg    <= count_reg + CNT_W'(1);
                                    wr_reg        <= 1'b1;
                                end
                            end
                            OP_FINISH:
                            begin
                                if (count_reg == CNT_W'(1))
                                begin
                                    res_value_reg <= top_reg;
                                end
                                else
                                begin
                                    res_status_reg <= ST_REMAIN;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                            begin
                                if (count_reg < CNT_W'(2))
                                begin
                                    res_status_reg <= ST_FEW;
                                end
                                else
                                begin
                                    state_reg <= S_CALC;
                                end
                            end
                            default:
                            begin
                                // unused code: report current top
                                res_value_reg <= (count_reg == '0) ? '0 : top_reg;
                                ncount_reg    <= count_reg;
                            end
                        endcase
                    end
                end

                S_CALC:
                begin
                    // rd_data_reg holds second, top_reg holds top
                    ncount_reg <= count_reg - CNT_W'(1);
                    wr_reg     <= 1'b1;
                    state_reg  <= S_DONE;
                    case (op_reg)
                        OP_ADD:  res_value_reg <= rd_data_reg + top_reg;
                        OP_SUB:  res_value_reg <= rd_data_reg - top_reg;
                        OP_MUL:  res_value_reg <= VAL_W'(rd_data_reg * top_reg);
                        default:
                        begin
                            if (top_reg == '0)
                            begin
                                res_status_reg <= ST_DIV_ZERO;
                                res_value_reg  <= '0;
                                ncount_reg     <= '0;
                                wr_reg         <= 1'b0;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                    endcase
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_value_reg <= div_quot;
                        state_reg     <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        top_value_reg <= res_value_reg;
                        depth_reg     <= DEPTH_W'(ncount_reg);
                        count_reg     <= ncount_reg;
                        top_reg       <= res_value_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign top_value = top_value_reg;
    assign depth     = depth_reg;

`ifndef NO_ASSERTIONS
    // Stack count never passes the memory depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // Write-back only lands on an entry inside the new stack
    a_write_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (ncount_reg != '0) && (ncount_reg <= CNT_W'(STACK_DEPTH)))
        else $error("stack write outside held entries");

    // Divider result only arrives while it is awaited
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside divide wait");

    // A taken token blocks the input on the next cycle
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second token taken while busy");
`endif

endmodule

### sim/tb_rpn_stack_evaluator_core.sv
module tb_rpn_stack_evaluator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;

    // Spare op codes, reported without change
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [NUM_W-1:0] number;
    } token_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    top_value;
        logic [DEPTH_W-1:0]  depth;
    } answer_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op        = OP_PUSH;
    logic [NUM_W-1:0]    number    = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    top_value;
    logic [DEPTH_W-1:0]  depth;

    token_t  tokens_pending[$];
    answer_t answers_due[$];

    // Shadow of the calculator stack
    logic [VAL_W-1:0] calc_stack [0:STACK_DEPTH-1];
    int               calc_count = 0;

    int fail_count    = 0;
    int tokens_queued = 0;
    int src_gap       = 0;
    int snk_cnt       = 0;
    int quiet_cycles  = 0;
    int hold_reqs     = 0;
    int holds_done    = 0;
    bit in_idle_en    = 1'b0;
    bit out_idle_en   = 1'b0;

    rpn_stack_evaluator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .top_value (top_value),
        .depth     (depth)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected result of one token; updates the shadow stack
    function automatic answer_t evaluate_token(input logic [OP_W-1:0] opc,
                                               input logic [NUM_W-1:0] num);
        answer_t          ans;
        logic [VAL_W-1:0] lhs;
        logic [VAL_W-1:0] rhs;
        logic [VAL_W-1:0] res;
        logic [VAL_W-1:0] mag_l;
        logic [VAL_W-1:0] mag_r;
        logic [VAL_W-1:0] quo;
        bit               finished;
        ans.status = ST_OK;
        finished   = 1'b0;
        res        = '0;
        if (opc == OP_PUSH)
        begin
            if (calc_count >= STACK_DEPTH)
                ans.status = ST_FULL;
            else
            begin
                calc_stack[calc_count] = {1'b0, num};
                calc_count++;
            end
        end
        else if (opc == OP_FINISH)
        begin
            if (calc_count != 1)
                ans.status = ST_REMAIN;
            else
            begin
                res        = calc_stack[0];
                calc_count = 0;
                finished   = 1'b1;
            end
        end
        else if (opc > OP_FINISH)
        begin
            // unused codes: report only
        end
        else if (calc_count < 2)
            ans.status = ST_FEW;
        else
        begin
            rhs = calc_stack[calc_count-1];
            lhs = calc_stack[calc_count-2];
            case (opc)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                default:
                begin
                    // truncating divide on magnitudes, sign applied after
                    mag_l = lhs[VAL_W-1] ? -lhs : lhs;
                    mag_r = rhs[VAL_W-1] ? -rhs : rhs;
                    quo   = (rhs == '0) ? '0 : mag_l / mag_r;
                    res   = (lhs[VAL_W-1] ^ rhs[VAL_W-1]) ? -quo : quo;
                end
            endcase
            if (opc == OP_DIV && rhs == '0)
                ans.status = ST_DIV_ZERO;
            else
            begin
                calc_count--;
                calc_stack[calc_count-1] = res;
            end
        end
        if (ans.status != ST_OK)
        begin
            calc_count    = 0;
            ans.top_value = '0;
            ans.depth     = '0;
        end
        else if (finished)
        begin
            ans.top_value = res;
            ans.depth     = '0;
        end
        else
        begin
            ans.top_value = (calc_count != 0) ? calc_stack[calc_count-1] : '0;
            ans.depth     = DEPTH_W'(calc_count);
        end
        return ans;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(1, 2);
        else if (pick < 9)
            return $urandom_range(3, 8);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [NUM_W-1:0] rand_num();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return NUM_W'($urandom_range(1, 100));
            5, 6:    return NUM_W'($urandom_range(0, 65535));
            default: return NUM_W'($urandom);
        endcase
    endfunction

    task automatic add_token(input logic [OP_W-1:0] opc, input logic [NUM_W-1:0] num);
        token_t tok;
        tok.op     = opc;
        tok.number = num;
        tokens_pending.push_back(tok);
        tokens_queued++;
    endtask

    // Well-formed expression with random operands, sometimes spoiled at the end
    task automatic gen_expr();
        int operands;
        int pushed;
        int level;
        int tail;
        operands = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                               : $urandom_range(1, 6);
        pushed   = 0;
        level    = 0;
        while (pushed < operands || level > 1)
        begin
            if (pushed < operands && (level < 2 || $urandom_range(0, 1) == 0))
            begin
                add_token(OP_PUSH, rand_num());
                pushed++;
                level++;
            end
            else
            begin
                add_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), NUM_W'($urandom));
                level--;
            end
        end
        tail = $urandom_range(0, 19);
        if (tail == 1)
            add_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), NUM_W'($urandom));
        if (tail != 0)
            add_token(OP_FINISH, NUM_W'($urandom));
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 4))
            add_token(OP_W'($urandom_range(0, 7)), NUM_W'($urandom));
    endtask

    // Run the stack up to full, then overflow it or finish with values left
    task automatic gen_fill();
        add_token(OP_FINISH, '0);
        repeat (STACK_DEPTH)
            add_token(OP_PUSH, rand_num());
        case ($urandom_range(0, 2))
            0: add_token(OP_PUSH, rand_num());
            1:
            begin
                add_token(OP_SPARE_7, NUM_W'($urandom));
                add_token(OP_PUSH, rand_num());
            end
            default:
            begin
                repeat ($urandom_range(1, 5))
                    add_token(OP_W'($urandom_range(OP_ADD, OP_DIV)), '0);
                add_token(OP_FINISH, '0);
            end
        endcase
    endtask

    task automatic gen_random(input int count);
        int target;
        int pick;
        target = tokens_queued + count;
        while (tokens_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                gen_expr();
            else if (pick < 94)
                gen_noise();
            else
                gen_fill();
        end
    endtask

    task automatic drain_tokens();
        while (tokens_pending.size() != 0)
            @(posedge clk);
    endtask

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= OP_PUSH;
            number   <= '0;
            src_gap  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                answers_due.push_back(evaluate_token(op, number));
                src_gap = (in_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
            end
            if (!(in_valid && in_stall))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (tokens_pending.size() != 0)
                begin
                    in_valid <= 1'b1;
                    op       <= tokens_pending[0].op;
                    number   <= tokens_pending[0].number;
                    void'(tokens_pending.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            snk_cnt   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d top %0d depth %0d",
                           status, $signed(top_value), depth);
                    fail_count++;
                end
                else
                begin
                    if (status !== answers_due[0].status)
                    begin
                        $error("status: expected %0d, got %0d",
                               answers_due[0].status, status);
                        fail_count++;
                    end
                    if (top_value !== answers_due[0].top_value)
                    begin
                        $error("top_value: expected %0d, got %0d",
                               $signed(answers_due[0].top_value), $signed(top_value));
                        fail_count++;
                    end
                    if (depth !== answers_due[0].depth)
                    begin
                        $error("depth: expected %0d, got %0d",
                               answers_due[0].depth, depth);
                        fail_count++;
                    end
                    void'(answers_due.pop_front());
                end
            end
            if (snk_cnt > 0)
            begin
                snk_cnt--;
                out_stall <= 1'b1;
            end
            else if (hold_reqs != holds_done)
            begin
                holds_done++;
                snk_cnt = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (out_idle_en && $urandom_range(0, 3) == 0)
            begin
                snk_cnt = idle_len() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on handshake progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
            calc_stack[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: errors on empty stack, wrap-around, divide corners, finishes
        add_token(OP_ADD, '0);
        add_token(OP_FINISH, '0);
        add_token(OP_SPARE_6, '1);
        add_token(OP_PUSH, '1);
        add_token(OP_PUSH, 31'd1);
        add_token(OP_ADD, '0);
        add_token(OP_PUSH, '0);
        add_token(OP_PUSH, 31'd1);
        add_token(OP_SUB, '0);
        add_token(OP_DIV, '0);
        add_token(OP_SPARE_7, '0);
        add_token(OP_PUSH, '1);
        add_token(OP_MUL, '0);
        add_token(OP_PUSH, 31'd3);
        add_token(OP_DIV, '0);
        add_token(OP_PUSH, '0);
        add_token(OP_DIV, '0);
        add_token(OP_PUSH, 31'd7);
        add_token(OP_PUSH, 31'd2);
        add_token(OP_FINISH, '0);
        add_token(OP_PUSH, 31'd7);
        add_token(OP_PUSH, 31'd9);
        add_token(OP_SUB, '0);
        add_token(OP_FINISH, '0);
        drain_tokens();

        // Back to back, no idling
        gen_fill();
        gen_random(200);
        drain_tokens();

        // Idling on both sides
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        gen_random(350);
        drain_tokens();

        // Long receiver hold while the sender keeps offering
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        hold_reqs++;
        gen_random(150);
        drain_tokens();

        // Sender gaps only
        in_idle_en = 1'b1;
        gen_random(150);
        drain_tokens();

        // Receiver stalls only
        in_idle_en  = 1'b0;
        out_idle_en = 1'b1;
        gen_random(150);
        drain_tokens();

        while (answers_due.size() != 0 || in_valid)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
